// ===== sv/mhpq_pkg.sv =====
`default_nettype none
package mhpq_pkg;

  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    logic ins;
    logic del;
    key_t key;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ===== sv/mhpq_in_if.sv =====
`default_nettype none
interface mhpq_in_if import mhpq_pkg::*; ();
  logic valid;
  logic ready;
  logic kind;
  key_t key;

  modport source (output valid, output kind, output key, input ready);
  modport sink (input valid, input kind, input key, output ready);
endinterface
`default_nettype wire

// ===== sv/mhpq_out_if.sv =====
`default_nettype none
interface mhpq_out_if import mhpq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  key_t                removed_key;
  key_t                top_key;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, output status, output removed_key, output top_key,
                  output count, input ready);
  modport sink (input valid, input status, input removed_key, input top_key,
                input count, output ready);
endinterface
`default_nettype wire

// ===== sv/mhpq_cell.sv =====
`default_nettype none
module mhpq_cell import mhpq_pkg::*; (
  input  wire logic      clk,
  input  wire cell_cmd_t cmd,
  input  wire logic      valid,
  input  wire key_t      left_key,
  input  wire logic      left_ge,
  input  wire key_t      right_key,
  output key_t           key_r,
  output logic           ge
);

  key_t key_nxt;

  assign ge = valid && (key_r >= cmd.key);

  always_comb begin
    key_nxt = key_r;
    if (cmd.ins) begin
      if (ge) begin
        key_nxt = key_r;
      end else if (left_ge) begin
        key_nxt = cmd.key;
      end else begin
        key_nxt = left_key;
      end
    end else if (cmd.del) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule
`default_nettype wire

// ===== sv/max_heap_priority_queue_top.sv =====
// Max priority queue held as a sorted chain of CAPACITY cells, largest key first.
// The result is registered and appears in the cycle after the input transaction is accepted.
// Throughput: one transaction per cycle while the output is not stalled; every cell shifts or holds in that same cycle.
// Input is taken while the output register is empty or being drained.
// Reset (rst_n low, synchronous) empties the queue and the output register; cell keys
// are not cleared.
`default_nettype none
module max_heap_priority_queue_top import mhpq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input wire logic    clk,
  input wire logic    rst_n,
  mhpq_in_if.sink     in_ch,
  mhpq_out_if.source  out_ch
);

  localparam int CW = $clog2(CAPACITY + 1);

  key_t            cell_key [CAPACITY];
  logic            cell_ge  [CAPACITY];
  logic [CW-1:0]   count_r, count_nxt;
  cell_cmd_t       cmd;
  logic            in_fire;
  logic            full, empty;

  logic                out_valid_r;
  logic [STATUS_W-1:0] status_nxt, status_r;
  key_t                removed_nxt, removed_r;
  key_t                top_nxt, top_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CW'(CAPACITY));
  assign empty       = (count_r == '0);

  always_comb begin
    cmd.ins     = in_fire && (in_ch.kind == OP_INSERT) && !full;
    cmd.del     = in_fire && (in_ch.kind == OP_DELETE) && !empty;
    cmd.key     = in_ch.key;
    count_nxt   = count_r;
    status_nxt  = ST_DONE;
    removed_nxt = '0;
    top_nxt     = empty ? key_t'(0) : cell_key[0];
    if (in_ch.kind == OP_INSERT) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + CW'(1);
        if (empty || (in_ch.key > cell_key[0])) begin
          top_nxt = in_ch.key;
        end
      end
    end else begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        count_nxt   = count_r - CW'(1);
        removed_nxt = cell_key[0];
        top_nxt     = (count_r > CW'(1)) ? cell_key[1] : key_t'(0);
      end
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      key_t lk, rk;
      logic lg;
      if (i == 0) begin : g_first
        assign lk = in_ch.key;
        assign lg = 1'b1;
      end else begin : g_mid
        assign lk = cell_key[i-1];
        assign lg = cell_ge[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign rk = cell_key[i];
      end else begin : g_inner
        assign rk = cell_key[i+1];
      end
      mhpq_cell u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .valid     (count_r > CW'(i)),
        .left_key  (lk),
        .left_ge   (lg),
        .right_key (rk),
        .key_r     (cell_key[i]),
        .ge        (cell_ge[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
      top_r     <= top_nxt;
    end
  end

  logic [COUNT_W-1:0] count_out_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      count_out_r <= COUNT_W'(count_nxt);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.removed_key = removed_r;
  assign out_ch.top_key     = top_r;
  assign out_ch.count       = count_out_r;

endmodule
`default_nettype wire
